// ----- rtl/core/tsp_pkg.sv -----
// Package for the trapezoid setpoint profile: field widths, constants,
// register indexes and the structs between the top level and the tick reducer.
// Depends on nothing; every other file of the block uses it by scoped names.
package tsp_pkg;

  // Control ticks per second of profile time.
  localparam int unsigned TICK_RATE = 1000;

  // Field widths.
  localparam int unsigned SP_W     = 40;  // signed Q23.16 speed
  localparam int unsigned BASE_W   = 16;  // whole RPM
  localparam int unsigned SEC_W    = 10;  // segment length in seconds
  localparam int unsigned INC_W    = 32;  // unsigned Q16.16 step
  localparam int unsigned TICK_W   = 22;  // tick counter
  localparam int unsigned FRAC_W   = 16;  // fraction bits of the speeds
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned BIT_IDX_W = 5;  // counts TICK_W - 1 down to 0

  // Arming window of 5 RPM in Q23.16.
  localparam logic signed [SP_W+1:0] NEAR_WINDOW = 42'sd5 <<< FRAC_W;

  // Saturation limits of the setpoint.
  localparam logic signed [SP_W-1:0] SP_MAX = {1'b0, {(SP_W-1){1'b1}}};
  localparam logic signed [SP_W-1:0] SP_MIN = {1'b1, {(SP_W-1){1'b0}}};

  // Register values after reset.
  localparam logic [BASE_W-1:0] BASE_SPEED_RST     = 16'd50;
  localparam logic [SEC_W-1:0]  RISE_SECONDS_RST   = 10'd10;
  localparam logic [SEC_W-1:0]  HOLD_SECONDS_RST   = 10'd5;
  localparam logic [SEC_W-1:0]  FALL_SECONDS_RST   = 10'd1;
  localparam logic [INC_W-1:0]  RISE_INCREMENT_RST = 32'd125;
  localparam logic [INC_W-1:0]  FALL_INCREMENT_RST = 32'd1245;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_SPEED     = 3'd0,
    CFG_RISE_SECONDS   = 3'd1,
    CFG_HOLD_SECONDS   = 3'd2,
    CFG_FALL_SECONDS   = 3'd3,
    CFG_RISE_INCREMENT = 3'd4,
    CFG_FALL_INCREMENT = 3'd5
  } cfg_idx_t;

  // Request to the tick reducer: reduce tick modulo period.
  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] tick;
    logic [TICK_W-1:0] period;
  } red_req_t;

  // Status from the tick reducer.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TICK_W-1:0] rem;
  } red_stat_t;

  // Seconds times the tick rate, as a tick count.
  function automatic logic [TICK_W-1:0] to_ticks(input logic [SEC_W+1:0] secs);
    to_ticks = TICK_W'(secs) * TICK_W'(TICK_RATE);
  endfunction

endpackage

// ----- rtl/core/tsp_ifs.sv -----
// Channel interfaces of the trapezoid setpoint profile: input ticks,
// result setpoints and configuration writes. Depends on tsp_pkg.
interface tsp_in_if;
  logic                             valid;
  logic                             ready;
  logic                             restart;
  logic signed [tsp_pkg::SP_W-1:0]  measured_speed;

  modport source (output valid, restart, measured_speed, input ready);
  modport sink   (input valid, restart, measured_speed, output ready);
endinterface

interface tsp_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tsp_pkg::SP_W-1:0]  speed_setpoint;

  modport source (output valid, speed_setpoint, input ready);
  modport sink   (input valid, speed_setpoint, output ready);
endinterface

interface tsp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tsp_pkg::CFG_IDX_W-1:0]     index;
  logic [tsp_pkg::CFG_DAT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/tsp_tick_reduce.sv -----
// Restoring reducer that brings a tick count below a new period, one
// quotient bit per cycle. Depends on tsp_pkg.
module tsp_tick_reduce (
  input  logic               clk,
  input  logic               rst_n,
  input  tsp_pkg::red_req_t  req,
  output tsp_pkg::red_stat_t stat
);

  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic [tsp_pkg::BIT_IDX_W-1:0]  bit_r, bit_nxt;
  logic [tsp_pkg::TICK_W-1:0]     rem_r, rem_nxt;
  logic [2*tsp_pkg::TICK_W-2:0]   shifted;
  logic                           take;

  // Compare the remainder against the period shifted to the current bit.
  always_comb begin
    shifted = (2*tsp_pkg::TICK_W-1)'(req.period) << bit_r;
    take    = (2*tsp_pkg::TICK_W-1)'(rem_r) >= shifted;
  end

  // Step control: load on start, then walk the bits down to zero.
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      run_nxt = 1'b1;
      bit_nxt = tsp_pkg::BIT_IDX_W'(tsp_pkg::TICK_W - 1);
      rem_nxt = req.tick;
    end else if (run_r) begin
      if (take) begin
        rem_nxt = rem_r - shifted[tsp_pkg::TICK_W-1:0];
      end
      if (bit_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        bit_nxt = bit_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = run_r | done_r;
  assign stat.done = done_r;
  assign stat.rem  = rem_r;

endmodule

// ----- rtl/core/trapezoid_setpoint_profile.sv -----
// Trapezoid setpoint profile: input register, one pass of setpoint logic,
// result register. One tick is taken every cycle while the result register
// does not stall and no configuration write is in progress. A configuration
// write holds off input from its own cycle until the tick reducer has brought
// the counter below the new period. Reset (rst_n, synchronous, active low)
// loads the register defaults and clears counter, setpoint and armed flag.
// Depends on tsp_pkg, tsp_ifs and tsp_tick_reduce.
module trapezoid_setpoint_profile (
  input  logic       clk,
  input  logic       rst_n,
  tsp_in_if.sink     in_ch,
  tsp_out_if.source  out_ch,
  tsp_cfg_if.sink    cfg_ch
);

  localparam int unsigned SP_W   = tsp_pkg::SP_W;
  localparam int unsigned TICK_W = tsp_pkg::TICK_W;

  // Configuration registers.
  logic [tsp_pkg::BASE_W-1:0] base_speed_r;
  logic [tsp_pkg::SEC_W-1:0]  rise_seconds_r, hold_seconds_r, fall_seconds_r;
  logic [tsp_pkg::INC_W-1:0]  rise_increment_r, fall_increment_r;

  // Segment ends in ticks, derived from the registers.
  logic [TICK_W-1:0] rise_end_r, hold_end_r, period_r;

  // Pipeline and profile state.
  logic                    s1_valid_r, s1_valid_nxt;
  logic                    s1_restart_r;
  logic signed [SP_W-1:0]  s1_meas_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SP_W-1:0]  sp_r, sp_nxt;
  logic                    armed_r, armed_nxt;
  logic [TICK_W-1:0]       tick_r, tick_nxt;
  logic [TICK_W-1:0]       red_r, red_nxt;
  logic                    cfg_wr_q_r;

  logic                    cfg_acc, in_acc, s2_adv, busy, reload, near;
  logic signed [SP_W-1:0]  base40;
  logic signed [SP_W+1:0]  diff;
  logic signed [SP_W:0]    sum_up, sum_dn;
  logic [TICK_W-1:0]       tick_base, tick_inc;

  tsp_pkg::red_req_t  red_req;
  tsp_pkg::red_stat_t red_stat;

  // Configuration port: always ready, unknown indexes are ignored.
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r     <= tsp_pkg::BASE_SPEED_RST;
      rise_seconds_r   <= tsp_pkg::RISE_SECONDS_RST;
      hold_seconds_r   <= tsp_pkg::HOLD_SECONDS_RST;
      fall_seconds_r   <= tsp_pkg::FALL_SECONDS_RST;
      rise_increment_r <= tsp_pkg::RISE_INCREMENT_RST;
      fall_increment_r <= tsp_pkg::FALL_INCREMENT_RST;
    end else if (cfg_acc) begin
      unique case (tsp_pkg::cfg_idx_t'(cfg_ch.index))
        tsp_pkg::CFG_BASE_SPEED:     base_speed_r <= cfg_ch.data[tsp_pkg::BASE_W-1:0];
        tsp_pkg::CFG_RISE_SECONDS:   rise_seconds_r <= cfg_ch.data[tsp_pkg::SEC_W-1:0];
        tsp_pkg::CFG_HOLD_SECONDS:   hold_seconds_r <= cfg_ch.data[tsp_pkg::SEC_W-1:0];
        tsp_pkg::CFG_FALL_SECONDS:   fall_seconds_r <= cfg_ch.data[tsp_pkg::SEC_W-1:0];
        tsp_pkg::CFG_RISE_INCREMENT: rise_increment_r <= cfg_ch.data;
        tsp_pkg::CFG_FALL_INCREMENT: fall_increment_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Segment ends are registered from the registers and follow them in the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_end_r <= tsp_pkg::to_ticks(12'(tsp_pkg::RISE_SECONDS_RST));
      hold_end_r <= tsp_pkg::to_ticks(12'(tsp_pkg::RISE_SECONDS_RST)
                                      + 12'(tsp_pkg::HOLD_SECONDS_RST));
      period_r   <= tsp_pkg::to_ticks(12'(tsp_pkg::RISE_SECONDS_RST)
                                      + 12'(tsp_pkg::HOLD_SECONDS_RST)
                                      + 12'(tsp_pkg::FALL_SECONDS_RST));
      cfg_wr_q_r <= 1'b0;
    end else begin
      rise_end_r <= tsp_pkg::to_ticks(12'(rise_seconds_r));
      hold_end_r <= tsp_pkg::to_ticks(12'(rise_seconds_r) + 12'(hold_seconds_r));
      period_r   <= tsp_pkg::to_ticks(12'(rise_seconds_r) + 12'(hold_seconds_r)
                                      + 12'(fall_seconds_r));
      cfg_wr_q_r <= cfg_acc;
    end
  end

  // The reducer keeps a copy of the counter taken modulo the period.
  assign red_req.start  = cfg_wr_q_r;
  assign red_req.tick   = tick_r;
  assign red_req.period = period_r;

  tsp_tick_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (red_req),
    .stat  (red_stat)
  );

  // A write in progress also blocks input, so no tick meets stale segment ends.
  assign busy = cfg_acc | cfg_wr_q_r | red_stat.busy;

  // Handshakes: the input register moves on when the result register frees.
  assign s2_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !busy && (!s1_valid_r || s2_adv);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Reload check and arming window.
  always_comb begin
    reload = s1_restart_r || (tick_r == '0) || !armed_r;
    base40 = SP_W'({base_speed_r, {tsp_pkg::FRAC_W{1'b0}}});
    diff   = (SP_W+2)'(base40) - (SP_W+2)'(s1_meas_r);
    near   = (diff > -tsp_pkg::NEAR_WINDOW) && (diff < tsp_pkg::NEAR_WINDOW);
  end

  // Setpoint update: reload to the base speed, or a saturating step by segment.
  always_comb begin
    sum_up = (SP_W+1)'(sp_r) + $signed({9'b0, rise_increment_r});
    sum_dn = (SP_W+1)'(sp_r) - $signed({9'b0, fall_increment_r});
    sp_nxt    = sp_r;
    armed_nxt = armed_r;
    if (reload) begin
      sp_nxt    = base40;
      armed_nxt = (armed_r && !s1_restart_r) || near;
    end else if (tick_r <= rise_end_r) begin
      if (sum_up[SP_W] != sum_up[SP_W-1]) begin
        sp_nxt = tsp_pkg::SP_MAX;
      end else begin
        sp_nxt = sum_up[SP_W-1:0];
      end
    end else if (tick_r <= hold_end_r) begin
      sp_nxt = sp_r;
    end else if (tick_r <= period_r) begin
      if (sum_dn[SP_W] != sum_dn[SP_W-1]) begin
        sp_nxt = tsp_pkg::SP_MIN;
      end else begin
        sp_nxt = sum_dn[SP_W-1:0];
      end
    end
  end

  // Counter advance, wrapping at the period; the reduced copy is below it.
  always_comb begin
    tick_base = reload ? '0 : red_r;
    tick_inc  = tick_base + 1'b1;
    if ((period_r == '0) || (tick_inc == period_r)) begin
      tick_nxt = '0;
    end else begin
      tick_nxt = tick_inc;
    end
    red_nxt = red_r;
    if (s2_adv) begin
      red_nxt = tick_nxt;
    end else if (red_stat.done) begin
      red_nxt = red_stat.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sp_r        <= '0;
      armed_r     <= 1'b0;
      tick_r      <= '0;
      red_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      red_r       <= red_nxt;
      if (s2_adv) begin
        sp_r    <= sp_nxt;
        armed_r <= armed_nxt;
        tick_r  <= tick_nxt;
      end
    end
    if (in_acc) begin
      s1_restart_r <= in_ch.restart;
      s1_meas_r    <= in_ch.measured_speed;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.speed_setpoint = sp_r;

`ifndef SYNTH
  // The reduced counter stays below a nonzero period whenever ticks can enter.
  a_red_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && period_r != '0) |-> (red_r < period_r))
    else $error("reduced tick count not below period");

  // No tick enters while the counter is being reduced.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("input ready during tick reduction");

  // A tick leaving the input register always shows up as a result.
  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv |=> out_valid_r)
    else $error("advanced tick produced no result");

  // A reload tick presents the base speed.
  a_reload_base: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && reload) |=> (sp_r == $past(base40)))
    else $error("reload did not present base speed");

  // Restart without the arming window leaves the block disarmed.
  a_restart_disarm: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && s1_restart_r && !near) |=> !armed_r)
    else $error("restart did not clear armed flag");
`endif

endmodule
